// ----- rtl/core/skht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skht_pkg
// Shared widths, codes and types for the sorted key and handle table.
// ----------------------------------------------------------------------------
package skht_pkg;

    localparam int KEY_W            = 32;
    localparam int HANDLE_W         = 32;
    localparam int STATUS_W         = 2;
    localparam int DEFAULT_CAPACITY = 128;

    localparam int S_TDATA_W = KEY_W + HANDLE_W;
    localparam int M_TDATA_W = HANDLE_W;

    // request kinds, carried on s_tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // result status, carried on m_tuser
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_FULL      = 2'd2;

    // outcome of the shared key comparator
    typedef struct packed {
        logic gt;   // stored key larger than the request key
        logic eq;   // stored key equal to the request key
    } cmp_res_t;

endpackage

// ----- rtl/core/skht_cmp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skht_cmp
// Shared unsigned key comparator used by both the insert and lookup sweeps.
// ----------------------------------------------------------------------------
module skht_cmp (
    input  logic [skht_pkg::KEY_W-1:0] stored_key,
    input  logic [skht_pkg::KEY_W-1:0] req_key,
    output skht_pkg::cmp_res_t         res
);
    import skht_pkg::*;

    always_comb begin
        res.gt = (stored_key > req_key);
        res.eq = (stored_key == req_key);
    end

endmodule

// ----- rtl/core/sorted_key_handle_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_handle_table_unit
// Table of key and handle pairs kept in ascending key order.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on the s_ channel: s_tuser selects insert (0) or
//   lookup (1), s_tdata carries the key and, for an insert, the handle.
//   Every request yields exactly one result on the m_ channel: m_tuser is
//   the status (ok, not found, table full), m_tdata the handle found by a
//   lookup and zero otherwise.
//   One request is in flight at a time; s_tready is low from acceptance
//   until its result has been taken.
//   Insert shifts each stored entry with a larger key up one place,
//   through the single read and single write port of the entry memory.
//   Lookup scans the entries from the lowest key upward. Empty-table
//   and table-full requests skip the sweep. The result is registered.
//   A stalled receiver holds the result in place and blocks new requests.
//   Reset empties the table at once; memory contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_key_handle_table_unit #(
    parameter int CAPACITY = skht_pkg::DEFAULT_CAPACITY
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [skht_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] key, [63:32] handle_in
    input  logic                           s_tuser,   // [0] op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [skht_pkg::M_TDATA_W-1:0] m_tdata,   // [31:0] handle_out
    output logic [skht_pkg::STATUS_W-1:0]  m_tuser    // [1:0] status
);
    import skht_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_W + HANDLE_W;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_INS     = 5'b00010,
        S_INS_FIN = 5'b00100,
        S_LKP     = 5'b01000,
        S_RESP    = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [HANDLE_W-1:0]   hin_reg, hin_next;
    status_t               status_reg, status_next;
    logic [HANDLE_W-1:0]   hout_reg, hout_next;

    // entry memory: {handle, key}
    logic [EW-1:0]         mem [CAPACITY];
    logic [EW-1:0]         rdata_reg;
    logic [AW-1:0]         rd_addr;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [EW-1:0]         mem_wdata;

    logic                  s_acc;
    logic [KEY_W-1:0]      s_key;
    logic [HANDLE_W-1:0]   s_hin;
    cmp_res_t              cmp;

    assign s_key = s_tdata[KEY_W-1:0];
    assign s_hin = s_tdata[EW-1:KEY_W];
    assign s_acc = s_tvalid && s_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_RESP);
    assign m_tdata  = hout_reg;
    assign m_tuser  = status_reg;

    skht_cmp u_cmp (
        .stored_key (rdata_reg[KEY_W-1:0]),
        .req_key    (key_reg),
        .res        (cmp)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        hin_next    = hin_reg;
        status_next = status_reg;
        hout_next   = hout_reg;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg[AW-1:0];
        mem_wdata   = {hin_reg, key_reg};
        rd_addr     = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tuser == OP_INSERT) begin
                    rd_addr = AW'(count_reg - CW'(1));
                end
                if (s_acc) begin
                    key_next  = s_key;
                    hin_next  = s_hin;
                    hout_next = '0;
                    if (s_tuser == OP_INSERT) begin
                        if (count_reg == CW'(CAPACITY)) begin
                            status_next = ST_FULL;
                            state_next  = S_RESP;
                        end else if (count_reg == '0) begin
                            mem_we      = 1'b1;
                            mem_waddr   = '0;
                            mem_wdata   = {s_hin, s_key};
                            count_next  = count_reg + CW'(1);
                            status_next = ST_OK;
                            state_next  = S_RESP;
                        end else begin
                            pos_next   = count_reg;
                            state_next = S_INS;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = ST_NOT_FOUND;
                            state_next  = S_RESP;
                        end else begin
                            pos_next   = '0;
                            state_next = S_LKP;
                        end
                    end
                end
            end
            S_INS: begin
                // rdata holds the entry just below pos
                rd_addr = AW'(pos_reg - CW'(2));
                mem_we  = 1'b1;
                if (cmp.gt) begin
                    // shift the larger entry up one place
                    mem_wdata = rdata_reg;
                    pos_next  = pos_reg - CW'(1);
                    if (pos_reg == CW'(1)) begin
                        state_next = S_INS_FIN;
                    end
                end else begin
                    count_next  = count_reg + CW'(1);
                    status_next = ST_OK;
                    state_next  = S_RESP;
                end
            end
            S_INS_FIN: begin
                mem_we      = 1'b1;
                mem_waddr   = '0;
                count_next  = count_reg + CW'(1);
                status_next = ST_OK;
                state_next  = S_RESP;
            end
            S_LKP: begin
                rd_addr = AW'(pos_reg + CW'(1));
                if (cmp.eq) begin
                    status_next = ST_OK;
                    hout_next   = rdata_reg[EW-1:KEY_W];
                    state_next  = S_RESP;
                end else if (cmp.gt || (pos_reg + CW'(1) == count_reg)) begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_RESP;
                end else begin
                    pos_next = pos_reg + CW'(1);
                end
            end
            S_RESP: begin
                // hold the result until the receiver takes it
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        hin_reg    <= hin_next;
        status_reg <= status_next;
        hout_reg   <= hout_next;
    end

endmodule

// ----- dv/tb_sorted_key_handle_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_key_handle_table_unit
// Self-checking bench for the sorted key and handle table. A queue of
// inserts and lookups feeds a stream driver; a shadow copy of the table
// predicts the status and handle of every accepted request, and the
// monitor compares each result against the oldest prediction. Both sides
// insert random idle and stall cycles, with occasional calm stretches.
// ----------------------------------------------------------------------------
module tb_sorted_key_handle_table_unit;
    import skht_pkg::*;

    localparam int TABLE_DEPTH  = DEFAULT_CAPACITY;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
    localparam int RANDOM_ITEMS = 1300;
    localparam int MAX_GAP      = 4;

    typedef struct {
        logic                op;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] hdl;
    } request_t;

    typedef struct {
        status_t             status;
        logic [HANDLE_W-1:0] hdl;
    } answer_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [31:0] key, [63:32] handle_in
    logic                 s_tuser  = 1'b0; // [0] op
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [31:0] handle_out
    logic [STATUS_W-1:0]  m_tuser;         // [1:0] status

    // shadow table
    logic [KEY_W-1:0]    tbl_key [TABLE_DEPTH];
    logic [HANDLE_W-1:0] tbl_hdl [TABLE_DEPTH];
    int                  tbl_count = 0;

    request_t            pending[$];
    answer_t             answers_due[$];
    logic [KEY_W-1:0]    known_keys[$];
    int                  queued_cnt   = 0;
    int                  accepted_cnt = 0;
    int                  result_cnt   = 0;
    int                  mismatch_cnt = 0;
    int                  gen_inserts  = 0;

    logic                req_fire = 1'b0;
    logic                res_fire = 1'b0;
    int                  tx_gap   = 0;
    int                  rx_wait  = 0;
    bit                  tx_calm  = 1'b0;
    bit                  rx_calm  = 1'b0;

    sorted_key_handle_table_unit #(
        .CAPACITY (TABLE_DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch on result %0d: %s", $realtime, result_cnt, msg);
        mismatch_cnt++;
    endtask

    // Apply one request to the shadow table and return its answer.
    function automatic answer_t apply_to_table(input logic op, input logic [KEY_W-1:0] key,
                                               input logic [HANDLE_W-1:0] hdl);
        answer_t ans;
        int      pos;
        bit      done;
        ans.status = ST_NOT_FOUND;
        ans.hdl    = '0;
        if (op == OP_INSERT) begin
            if (tbl_count >= TABLE_DEPTH) begin
                ans.status = ST_FULL;
            end else begin
                // bubble past strictly larger keys only, so duplicates keep order
                pos = tbl_count;
                while (pos > 0 && tbl_key[pos-1] > key) begin
                    tbl_key[pos] = tbl_key[pos-1];
                    tbl_hdl[pos] = tbl_hdl[pos-1];
                    pos--;
                end
                tbl_key[pos] = key;
                tbl_hdl[pos] = hdl;
                tbl_count++;
                ans.status = ST_OK;
            end
        end else begin
            pos  = 0;
            done = 1'b0;
            while (!done && pos < tbl_count) begin
                if (tbl_key[pos] > key) begin
                    done = 1'b1;
                end else if (tbl_key[pos] == key) begin
                    ans.status = ST_OK;
                    ans.hdl    = tbl_hdl[pos];
                    done       = 1'b1;
                end
                pos++;
            end
        end
        return ans;
    endfunction

    task automatic push_request(input logic op, input logic [KEY_W-1:0] key,
                                input logic [HANDLE_W-1:0] hdl);
        request_t r;
        r.op  = op;
        r.key = key;
        r.hdl = hdl;
        pending.push_back(r);
        queued_cnt++;
        if (op == OP_INSERT) begin
            gen_inserts++;
            known_keys.push_back(key);
        end
    endtask

    // Mix keys of earlier inserts, a narrow band full of duplicates, corner values
    // and full-range values.
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                if (known_keys.size() != 0) begin
                    k = known_keys[$urandom_range(0, known_keys.size() - 1)];
                end else begin
                    k = $urandom;
                end
            end
            4, 5: begin
                k = $urandom_range(0, 31);
            end
            6: begin
                case ($urandom_range(0, 3))
                    0: k = '0;
                    1: k = '1;
                    2: k = 32'h8000_0000;
                    default: k = 32'h7fff_ffff;
                endcase
            end
            default: begin
                k = $urandom;
            end
        endcase
        return k;
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_handle();
        logic [HANDLE_W-1:0] h;
        case ($urandom_range(0, 9))
            0: h = '0;
            1: h = '1;
            default: h = $urandom;
        endcase
        return h;
    endfunction

    // Sample both handshakes, check results and predict accepted requests.
    always @(posedge aclk) begin
        answer_t want;
        req_fire <= aresetn && s_tvalid && s_tready;
        res_fire <= aresetn && m_tvalid && m_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (answers_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result, status %0d handle %h",
                                          m_tuser, m_tdata));
            end else begin
                want = answers_due.pop_front();
                if (m_tuser !== want.status) begin
                    report_mismatch($sformatf("status %0d, wanted %0d", m_tuser, want.status));
                end
                if (m_tdata !== want.hdl) begin
                    report_mismatch($sformatf("handle %h, wanted %h", m_tdata, want.hdl));
                end
            end
            result_cnt++;
        end
        if (aresetn && s_tvalid && s_tready) begin
            answers_due.push_back(apply_to_table(s_tuser, s_tdata[KEY_W-1:0],
                                                 s_tdata[S_TDATA_W-1:KEY_W]));
            accepted_cnt++;
        end
    end

    // Request driver
    always @(negedge aclk) begin
        request_t nxt;
        if (aresetn && !(s_tvalid && !req_fire)) begin
            if (req_fire) begin
                if ($urandom_range(0, 31) == 0) begin
                    tx_calm = !tx_calm;
                end
                tx_gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (tx_gap > 0 || pending.size() == 0) begin
                s_tvalid <= 1'b0;
                if (tx_gap > 0) begin
                    tx_gap--;
                end
            end else begin
                nxt = pending.pop_front();
                s_tuser  <= nxt.op;
                s_tdata  <= {nxt.hdl, nxt.key};
                s_tvalid <= 1'b1;
            end
        end
    end

    // Result receiver: the stall counts down only while a result is offered
    always @(negedge aclk) begin
        if (res_fire) begin
            if ($urandom_range(0, 31) == 0) begin
                rx_calm = !rx_calm;
            end
            rx_wait = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
        end else if (m_tvalid && rx_wait > 0) begin
            rx_wait--;
        end
        m_tready <= aresetn && (rx_wait == 0);
    end

    initial begin
        int  n;
        bit  is_ins;

        // directed: empty table, extremes, duplicates, misses on every side
        push_request(OP_LOOKUP, 32'd5, 32'hffff_ffff);
        push_request(OP_INSERT, 32'hffff_ffff, 32'hffff_ffff);
        push_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
        push_request(OP_INSERT, 32'd100, 32'ha5a5_a5a5);
        push_request(OP_INSERT, 32'd100, 32'h5a5a_5a5a);
        push_request(OP_INSERT, 32'd50, 32'h0000_0001);
        push_request(OP_INSERT, 32'd100, 32'h0000_0003);
        push_request(OP_LOOKUP, 32'd100, 32'h0000_0000);
        push_request(OP_LOOKUP, 32'h0000_0000, 32'h1234_5678);
        push_request(OP_LOOKUP, 32'hffff_ffff, 32'h0000_0000);
        push_request(OP_LOOKUP, 32'd75, 32'h0000_0000);
        push_request(OP_LOOKUP, 32'd1, 32'h0000_0000);
        push_request(OP_LOOKUP, 32'hffff_fffe, 32'h0000_0000);
        push_request(OP_INSERT, 32'h8000_0000, 32'h1234_5678);
        push_request(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);
        push_request(OP_INSERT, 32'h0000_0000, 32'hdead_beef);
        push_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        push_request(OP_LOOKUP, 32'd50, 32'h0000_0000);

        // fill to capacity with mostly inserts, then mostly lookups plus
        // inserts that must bounce off the full table
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (gen_inserts < TABLE_DEPTH) begin
                is_ins = $urandom_range(0, 9) < 6;
            end else begin
                is_ins = $urandom_range(0, 9) < 2;
            end
            push_request(is_ins ? OP_INSERT : OP_LOOKUP, pick_key(), pick_handle());
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (accepted_cnt < queued_cnt || answers_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_cnt == 0 && answers_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/skht_pkg.sv
rtl/core/skht_cmp.sv
rtl/core/sorted_key_handle_table_unit.sv
dv/tb_sorted_key_handle_table_unit.sv
